@@ hdl/raycast_wall_column_span_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Wrap concurrent assertions so that synthesis builds see no checks.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_COLUMN_SPAN_MACROS_SVH
`define RAYCAST_WALL_COLUMN_SPAN_MACROS_SVH
`ifndef SYNTHESIS
`define RWCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rwcs assertion failed");
`define RWCS_CHECK(lbl, prop) `RWCS_ASSERT(lbl, clock, reset, prop)
`else
`define RWCS_ASSERT(lbl, clk, rst, prop)
`define RWCS_CHECK(lbl, prop)
`endif
`endif

@@ hdl/rwcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rwcs_pkg
// Constants, codes and shared types of the wall column renderer.
// ----------------------------------------------------------------------------
package rwcs_pkg;
   localparam int SCREEN_HEIGHT = 512;
   localparam int TEXTURE_SIZE  = 64;

   localparam int ROW_W  = $clog2(SCREEN_HEIGHT) + 1;
   localparam int TEX_W  = $clog2(TEXTURE_SIZE);
   localparam int DVD_W  = $clog2(SCREEN_HEIGHT) + 17;
   localparam int CNT_W  = $clog2(DVD_W + 1);
   localparam int POS_W  = 24;
   localparam int DIR_W  = 16;
   localparam int RGB_W  = 24;
   localparam int COL_W  = 11;
   localparam int FRAC_W = 16;
   localparam int TPOS_W = 32;
   localparam int PROD_W = POS_W + 1 + DIR_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [DVD_W-1:0] LH_NUM   = DVD_W'(SCREEN_HEIGHT * 65536);
   localparam logic [DVD_W-1:0] STEP_NUM = DVD_W'(TEXTURE_SIZE * 65536);
   localparam logic [DVD_W-1:0] HALF_H   = DVD_W'(SCREEN_HEIGHT / 2);

   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 2'd1;

   localparam logic [1:0] KIND_CEILING = 2'd0;
   localparam logic [1:0] KIND_WALL    = 2'd1;
   localparam logic [1:0] KIND_FLOOR   = 2'd2;

   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_SOUTH = 2'd1;
   localparam logic [1:0] FACE_WEST  = 2'd2;
   localparam logic [1:0] FACE_EAST  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_LH,
      ST_SPAN,
      ST_DIV_STEP,
      ST_POS
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic pixel;
      logic mul_load;
      logic div_start;
      logic div_sel;
      logic lh_load;
      logic span_load;
      logic step_load;
      logic pos_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;
endpackage

@@ hdl/rwcs_divider.sv @@
// ----------------------------------------------------------------------------
// rwcs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwcs_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rwcs_pkg::DVD_W-1:0]  dividend,
   input  logic [rwcs_pkg::DVD_W-1:0]  divisor,
   output logic [rwcs_pkg::DVD_W-1:0]  quotient,
   output logic                        done
);
   localparam int W = rwcs_pkg::DVD_W;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] dsr_ff, dsr_in;
   logic [rwcs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [W:0] trial;
   logic fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = rwcs_pkg::CNT_W'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? W'(trial - {1'b0, dsr_ff}) : W'(trial);
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rwcs_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

@@ hdl/rwcs_datapath.sv @@
// ----------------------------------------------------------------------------
// rwcs_datapath
// Column set-up arithmetic, column state, pixel generation and output register.
// ----------------------------------------------------------------------------
module rwcs_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  rwcs_pkg::ctrl_cmd_type           cmd,
   output rwcs_pkg::dp_status_type          status,
   input  logic                             csr_wen,
   input  logic [rwcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rwcs_pkg::RGB_W-1:0]       csr_wdata,
   input  logic [rwcs_pkg::COL_W-1:0]       req_column_index,
   input  logic                             req_hit_side,
   input  logic [rwcs_pkg::POS_W-1:0]       req_player_x,
   input  logic [rwcs_pkg::POS_W-1:0]       req_player_y,
   input  logic signed [rwcs_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [rwcs_pkg::DIR_W-1:0] req_dir_y,
   input  logic [rwcs_pkg::POS_W-1:0]       req_side_dist_x_in,
   input  logic [rwcs_pkg::POS_W-1:0]       req_side_dist_y_in,
   input  logic [rwcs_pkg::POS_W-1:0]       req_delta_x_in,
   input  logic [rwcs_pkg::POS_W-1:0]       req_delta_y_in,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [10:0]                      rsp_pixel_column,
   output logic [8:0]                       rsp_pixel_row,
   output logic [1:0]                       rsp_pixel_kind,
   output logic [23:0]                      rsp_flat_rgb,
   output logic [1:0]                       rsp_wall_face,
   output logic [5:0]                       rsp_texel_x,
   output logic [5:0]                       rsp_texel_y,
   output logic                             rsp_column_done
);
   localparam int W  = rwcs_pkg::DVD_W;
   localparam int RW = rwcs_pkg::ROW_W;
   localparam int TW = rwcs_pkg::TEX_W;

   logic [rwcs_pkg::RGB_W-1:0] ceiling_ff, floor_ff;

   logic                        side_ff;
   logic signed [rwcs_pkg::DIR_W-1:0] dir_x_ff, dir_y_ff;
   logic [rwcs_pkg::POS_W-1:0]  dist_ff, dist_in;
   logic [rwcs_pkg::FRAC_W-1:0] opos_ff;
   logic [rwcs_pkg::COL_W-1:0]  col_req_ff;
   logic signed [rwcs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [rwcs_pkg::POS_W:0]   dist_s;
   logic signed [rwcs_pkg::DIR_W-1:0] dir_s;
   logic [W-1:0] lh_ff, off_ff, off_in;

   logic [rwcs_pkg::COL_W-1:0]  column_ff;
   logic [RW-1:0]               row_ff, start_ff, end_ff, start_in, end_in;
   logic [TW-1:0]               tex_col_ff, tex_col_in;
   logic [rwcs_pkg::TPOS_W-1:0] tex_pos_ff, tex_step_ff;
   logic [1:0]                  face_ff, face_in;

   logic [W-1:0] half, end_sum, div_dividend, div_divisor, quotient;
   logic [rwcs_pkg::FRAC_W-1:0] frac;
   logic [rwcs_pkg::POS_W-1:0]  sd_sel, dd_sel;
   logic mirror, row_live, emit, div_done;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] o_col_ff;
   logic [8:0]  o_row_ff;
   logic [1:0]  o_kind_ff, o_kind_in, o_face_ff, o_face_in;
   logic [23:0] o_rgb_ff, o_rgb_in;
   logic [5:0]  o_tx_ff, o_tx_in, o_ty_ff, o_ty_in;
   logic        o_done_ff;

   rwcs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   always_comb begin
      sd_sel  = req_hit_side ? req_side_dist_y_in : req_side_dist_x_in;
      dd_sel  = req_hit_side ? req_delta_y_in : req_delta_x_in;
      dist_in = (sd_sel < dd_sel) ? '0 : sd_sel - dd_sel;
      dist_s  = {1'b0, dist_ff};
      dir_s   = side_ff ? dir_x_ff : dir_y_ff;
      prod_in = dist_s * dir_s;
      div_dividend = cmd.div_sel ? rwcs_pkg::STEP_NUM : rwcs_pkg::LH_NUM;
      if (cmd.div_sel)
         div_divisor = lh_ff;
      else
         div_divisor = (dist_ff == '0) ? W'(1) : W'(dist_ff);
   end

   // span, texture column and face from line height and product
   always_comb begin
      half    = lh_ff >> 1;
      end_sum = half + rwcs_pkg::HALF_H;
      if (half >= rwcs_pkg::HALF_H) begin
         start_in = '0;
         off_in   = half - rwcs_pkg::HALF_H;
      end else begin
         start_in = RW'(rwcs_pkg::HALF_H - half);
         off_in   = '0;
      end
      end_in = (end_sum >= W'(rwcs_pkg::SCREEN_HEIGHT)) ?
               RW'(rwcs_pkg::SCREEN_HEIGHT - 1) : RW'(end_sum);
      // floor shift of the product: low bits of the sum need only bits 29:14
      frac   = opos_ff + prod_ff[14 +: rwcs_pkg::FRAC_W];
      mirror = (!side_ff && dir_x_ff > 0) || (side_ff && dir_y_ff < 0);
      tex_col_in = mirror ? ~frac[rwcs_pkg::FRAC_W-1 -: TW]
                          : frac[rwcs_pkg::FRAC_W-1 -: TW];
      if (!side_ff)
         face_in = (dir_x_ff < 0) ? rwcs_pkg::FACE_NORTH : rwcs_pkg::FACE_SOUTH;
      else
         face_in = (dir_y_ff < 0) ? rwcs_pkg::FACE_WEST : rwcs_pkg::FACE_EAST;
   end

   // pixel classification
   always_comb begin
      row_live  = row_ff < RW'(rwcs_pkg::SCREEN_HEIGHT);
      emit      = cmd.pixel && row_live;
      o_kind_in = rwcs_pkg::KIND_FLOOR;
      o_rgb_in  = floor_ff;
      o_face_in = '0;
      o_tx_in   = '0;
      o_ty_in   = '0;
      if (row_ff < start_ff) begin
         o_kind_in = rwcs_pkg::KIND_CEILING;
         o_rgb_in  = ceiling_ff;
      end else if (row_ff <= end_ff) begin
         o_kind_in = rwcs_pkg::KIND_WALL;
         o_rgb_in  = '0;
         o_face_in = face_ff;
         o_tx_in   = 6'(tex_col_ff);
         o_ty_in   = 6'(tex_pos_ff[16 +: TW]);
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         side_ff    <= req_hit_side;
         dir_x_ff   <= req_dir_x;
         dir_y_ff   <= req_dir_y;
         dist_ff    <= dist_in;
         opos_ff    <= req_hit_side ? req_player_x[rwcs_pkg::FRAC_W-1:0]
                                    : req_player_y[rwcs_pkg::FRAC_W-1:0];
         col_req_ff <= req_column_index;
      end
      if (cmd.mul_load) prod_ff <= prod_in;
      if (cmd.lh_load)  lh_ff   <= quotient;
      if (cmd.span_load) off_ff <= off_in;
      if (emit) begin
         o_col_ff  <= column_ff;
         o_row_ff  <= 9'(row_ff);
         o_kind_ff <= o_kind_in;
         o_rgb_ff  <= o_rgb_in;
         o_face_ff <= o_face_in;
         o_tx_ff   <= o_tx_in;
         o_ty_ff   <= o_ty_in;
         o_done_ff <= row_ff == RW'(rwcs_pkg::SCREEN_HEIGHT - 1);
      end
      if (reset) begin
         ceiling_ff   <= '0;
         floor_ff     <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         tex_col_ff   <= '0;
         tex_pos_ff   <= '0;
         tex_step_ff  <= '0;
         face_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && csr_index == rwcs_pkg::CSR_CEILING) ceiling_ff <= csr_wdata;
         if (csr_wen && csr_index == rwcs_pkg::CSR_FLOOR)   floor_ff   <= csr_wdata;
         if (cmd.span_load) begin
            start_ff   <= start_in;
            end_ff     <= end_in;
            tex_col_ff <= tex_col_in;
            face_ff    <= face_in;
            column_ff  <= col_req_ff;
         end
         if (cmd.step_load)
            tex_step_ff <= (lh_ff == '0) ? '0 : rwcs_pkg::TPOS_W'(quotient);
         if (cmd.pos_load) begin
            tex_pos_ff <= rwcs_pkg::TPOS_W'(off_ff * tex_step_ff);
            row_ff     <= '0;
         end else if (emit) begin
            row_ff <= row_ff + 1'b1;
            if (o_kind_in == rwcs_pkg::KIND_WALL)
               tex_pos_ff <= tex_pos_ff + tex_step_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_column = o_col_ff;
   assign rsp_pixel_row    = o_row_ff;
   assign rsp_pixel_kind   = o_kind_ff;
   assign rsp_flat_rgb     = o_rgb_ff;
   assign rsp_wall_face    = o_face_ff;
   assign rsp_texel_x      = o_tx_ff;
   assign rsp_texel_y      = o_ty_ff;
   assign rsp_column_done  = o_done_ff;
endmodule

@@ hdl/rwcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rwcs_ctrl
// Sequencer for column set-up; passes pixel items straight to the datapath.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_span_macros.svh"
module rwcs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   input  logic                     req_command,
   input  rwcs_pkg::dp_status_type  status,
   output rwcs_pkg::ctrl_cmd_type   cmd,
   output logic                     busy
);
   rwcs_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rwcs_pkg::ST_IDLE:
            if (req_accept && !req_command) state_in = rwcs_pkg::ST_MUL;
         rwcs_pkg::ST_MUL:      state_in = rwcs_pkg::ST_DIV_LH;
         rwcs_pkg::ST_DIV_LH:
            if (status.div_done) state_in = rwcs_pkg::ST_SPAN;
         rwcs_pkg::ST_SPAN:     state_in = rwcs_pkg::ST_DIV_STEP;
         rwcs_pkg::ST_DIV_STEP:
            if (status.div_done) state_in = rwcs_pkg::ST_POS;
         rwcs_pkg::ST_POS:      state_in = rwcs_pkg::ST_IDLE;
         default:               state_in = rwcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = state_ff != rwcs_pkg::ST_IDLE;
      unique case (state_ff)
         rwcs_pkg::ST_IDLE: begin
            cmd.capture = req_accept && !req_command;
            cmd.pixel   = req_accept && req_command;
         end
         rwcs_pkg::ST_MUL: begin
            cmd.mul_load  = 1'b1;
            cmd.div_start = 1'b1;
         end
         rwcs_pkg::ST_DIV_LH:   cmd.lh_load = status.div_done;
         rwcs_pkg::ST_SPAN: begin
            cmd.span_load = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
         end
         rwcs_pkg::ST_DIV_STEP: cmd.step_load = status.div_done;
         rwcs_pkg::ST_POS:      cmd.pos_load = 1'b1;
         default:               cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rwcs_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   `RWCS_CHECK(a_capture_starts_setup, cmd.capture |=> state_ff == rwcs_pkg::ST_MUL)
   `RWCS_CHECK(a_div_done_when_waiting, status.div_done |-> (state_ff == rwcs_pkg::ST_DIV_LH || state_ff == rwcs_pkg::ST_DIV_STEP))
   `RWCS_CHECK(a_no_pixel_in_setup, busy |-> !cmd.pixel && !cmd.capture)
endmodule

@@ hdl/raycast_wall_column_span.sv @@
// ----------------------------------------------------------------------------
// raycast_wall_column_span
// Textured wall column renderer: one ray hit in, one column of pixels out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | req_valid/stall  | command, ray hit fields
//  rsp_    | out       | rsp_valid/stall  | one pixel per pixel item on rows 0-511
//  csr_    | in        | csr_wen          | index 0 ceiling, 1 floor colour
//
//  With the result side ready, pixels stream one per cycle through the
//  output register.
//  A begin item makes two passes of the shared one-bit-per-cycle divider,
//  first for the line height, then for the texture step.
//  Reset is synchronous and clears all column state to column 0 whose wall
//  span is row 0 alone.
//  A stalled result holds the input side for every item until it is taken.
// ----------------------------------------------------------------------------
module raycast_wall_column_span (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [10:0]                      req_column_index,
   input  logic                             req_hit_side,
   input  logic [23:0]                      req_player_x,
   input  logic [23:0]                      req_player_y,
   input  logic signed [15:0]               req_dir_x,
   input  logic signed [15:0]               req_dir_y,
   input  logic [23:0]                      req_side_dist_x_in,
   input  logic [23:0]                      req_side_dist_y_in,
   input  logic [23:0]                      req_delta_x_in,
   input  logic [23:0]                      req_delta_y_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [10:0]                      rsp_pixel_column,
   output logic [8:0]                       rsp_pixel_row,
   output logic [1:0]                       rsp_pixel_kind,
   output logic [23:0]                      rsp_flat_rgb,
   output logic [1:0]                       rsp_wall_face,
   output logic [5:0]                       rsp_texel_x,
   output logic [5:0]                       rsp_texel_y,
   output logic                             rsp_column_done,
   input  logic                             csr_wen,
   input  logic [rwcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [23:0]                      csr_wdata
);
   rwcs_pkg::ctrl_cmd_type  cmd;
   rwcs_pkg::dp_status_type status;
   logic busy, req_accept;

   // hold the input during set-up, or while a waiting pixel would be overwritten
   assign req_stall  = busy || (rsp_valid && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   rwcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   rwcs_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_column_index   (req_column_index),
      .req_hit_side       (req_hit_side),
      .req_player_x       (req_player_x),
      .req_player_y       (req_player_y),
      .req_dir_x          (req_dir_x),
      .req_dir_y          (req_dir_y),
      .req_side_dist_x_in (req_side_dist_x_in),
      .req_side_dist_y_in (req_side_dist_y_in),
      .req_delta_x_in     (req_delta_x_in),
      .req_delta_y_in     (req_delta_y_in),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_column   (rsp_pixel_column),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_pixel_kind     (rsp_pixel_kind),
      .rsp_flat_rgb       (rsp_flat_rgb),
      .rsp_wall_face      (rsp_wall_face),
      .rsp_texel_x        (rsp_texel_x),
      .rsp_texel_y        (rsp_texel_y),
      .rsp_column_done    (rsp_column_done)
   );
endmodule
